// File: rtl/lrast_pkg.sv
// Shared types and constants for the range-add / range-sum tree core.
package lrast_pkg;

  localparam int unsigned LEAVES_DEF   = 1024;
  localparam int unsigned SUM_BITS_DEF = 64;
  localparam int unsigned IDX_W        = 11;
  localparam int unsigned AMT_W        = 32;
  localparam int unsigned RES_W        = 64;
  localparam int unsigned MUL_B_W      = 18;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_REVERSED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MA_AMT,
    MA_ACC_LO,
    MA_ACC_HI
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_LM1,
    MB_R,
    MB_LEN
  } mul_b_e;

  typedef enum logic [2:0] {
    PS_HOLD,
    PS_L,
    PS_R1,
    PS_R,
    PS_LM1,
    PS_UP,
    PS_DOWN,
    PS_INC
  } pos_e;

  typedef enum logic [1:0] {
    RS_HOLD,
    RS_CLEAR,
    RS_PROD,
    RS_ACC2
  } res_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_SET,
    S_A_RD,
    S_A_WR,
    S_A_TOT,
    S_Q_RD,
    S_Q_ACC,
    S_Q_MH,
    S_Q_C1,
    S_Q_C2,
    S_DONE
  } state_e;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  typedef struct packed {
    logic   load;
    pos_e   pos_op;
    logic   clr_wr;
    logic   mul_en;
    mul_a_e mul_a;
    mul_b_e mul_b;
    logic   set_dlt;
    logic   neg;
    logic   rd;
    logic   upd_wr;
    logic   acc_clr;
    logic   acc_add;
    res_e   res_op;
    logic   tot_add;
    logic   finish;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic op_query;
    logic pos_zero;
    logic pos_over;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: rtl/lrast_dpath.sv
// Datapath: two binary-indexed stores, walk position, shared multiplier, accumulators.
module lrast_dpath
  import lrast_pkg::*;
#(
  parameter int unsigned LEAVES   = LEAVES_DEF,
  parameter int unsigned SUM_BITS = SUM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic                    operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        last_index_i,
  input  logic signed [AMT_W-1:0] amount_i,
  output logic signed [RES_W-1:0] range_sum_o,
  output logic [1:0]              status_o,
  output logic                    total_is_zero_o
);

  localparam int unsigned AW    = $clog2(LEAVES + 1);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned DEPTH = LEAVES + 1;

  logic [SUM_BITS-1:0] b1_mem [DEPTH];
  logic [SUM_BITS-1:0] b2_mem [DEPTH];

  logic                    op_q;
  logic [PW-1:0]           l_q, r_q, pos_q, pos_d;
  logic signed [AMT_W-1:0] amt_q;
  status_e                 status_q, status_d;
  logic [SUM_BITS-1:0]     rd1_q, rd2_q, dlt1_q, dlt2_q, acc1_q, acc2_q;
  logic [SUM_BITS-1:0]     res_q, res_d, tot_q, amt_sx, prod_t, res_term;
  logic [RES_W-1:0]        prod_q, prod_d, acc_ext;
  logic signed [32:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_bu;
  logic signed [MUL_B_W:0] mul_b;
  logic signed [51:0]      mul_p;
  logic [PW-1:0]           lowbit;
  logic [AW-1:0]           addr;
  logic signed [RES_W-1:0] sum_out_q;
  status_e                 status_out_q;
  logic                    tz_q;

  always_comb begin
    if (32'(first_index_i) == 0 || 32'(last_index_i) == 0 ||
        32'(first_index_i) > LEAVES || 32'(last_index_i) > LEAVES) begin
      status_d = STATUS_RANGE;
    end else if (last_index_i < first_index_i) begin
      status_d = STATUS_REVERSED;
    end else begin
      status_d = STATUS_OK;
    end
  end

  assign amt_sx  = SUM_BITS'(amt_q);
  assign acc_ext = RES_W'(acc1_q);
  assign lowbit  = pos_q & (~pos_q + PW'(1));
  assign addr    = pos_q[AW-1:0];
  assign prod_t  = SUM_BITS'(prod_q);

  // shared multiplier: 33-bit signed by 19-bit signed
  always_comb begin
    case (cmd_i.mul_a)
      MA_AMT:    mul_a = 33'(amt_q);
      MA_ACC_LO: mul_a = signed'({1'b0, acc_ext[31:0]});
      MA_ACC_HI: mul_a = signed'({1'b0, acc_ext[63:32]});
      default:   mul_a = '0;
    endcase
    case (cmd_i.mul_b)
      MB_LM1:  mul_bu = MUL_B_W'(l_q - PW'(1));
      MB_R:    mul_bu = MUL_B_W'(r_q);
      MB_LEN:  mul_bu = MUL_B_W'(r_q - l_q + PW'(1));
      default: mul_bu = '0;
    endcase
    mul_b  = signed'({1'b0, mul_bu});
    mul_p  = mul_a * mul_b;
    prod_d = RES_W'(mul_p);
    if (cmd_i.mul_a == MA_ACC_HI) begin
      prod_d = prod_d << 32;
    end
  end

  always_comb begin
    case (cmd_i.pos_op)
      PS_L:    pos_d = l_q;
      PS_R1:   pos_d = r_q + PW'(1);
      PS_R:    pos_d = r_q;
      PS_LM1:  pos_d = l_q - PW'(1);
      PS_UP:   pos_d = pos_q + lowbit;
      PS_DOWN: pos_d = pos_q - lowbit;
      PS_INC:  pos_d = pos_q + PW'(1);
      default: pos_d = pos_q;
    endcase
  end

  always_comb begin
    res_term = (cmd_i.res_op == RS_ACC2) ? acc2_q : prod_t;
    case (cmd_i.res_op)
      RS_CLEAR: res_d = '0;
      RS_PROD,
      RS_ACC2:  res_d = cmd_i.neg ? res_q - res_term : res_q + res_term;
      default:  res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tot_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.tot_add) begin
        tot_q <= tot_q + prod_t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      l_q      <= PW'(first_index_i);
      r_q      <= PW'(last_index_i);
      amt_q    <= amount_i;
      status_q <= status_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.set_dlt) begin
      dlt1_q <= cmd_i.neg ? -amt_sx : amt_sx;
      dlt2_q <= cmd_i.neg ? -prod_t : prod_t;
    end
    if (cmd_i.acc_clr) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc1_q <= acc1_q + rd1_q;
      acc2_q <= acc2_q + rd2_q;
    end
    res_q <= res_d;
    if (cmd_i.finish) begin
      sum_out_q    <= (op_q && status_q == STATUS_OK) ? RES_W'(signed'(res_q)) : '0;
      status_out_q <= status_q;
      tz_q         <= (tot_q == '0);
    end
  end

  // stores: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd1_q <= b1_mem[addr];
      rd2_q <= b2_mem[addr];
    end
    if (cmd_i.clr_wr) begin
      b1_mem[addr] <= '0;
      b2_mem[addr] <= '0;
    end else if (cmd_i.upd_wr) begin
      b1_mem[addr] <= rd1_q + dlt1_q;
      b2_mem[addr] <= rd2_q + dlt2_q;
    end
  end

  assign stat_o.err      = (status_q != STATUS_OK);
  assign stat_o.op_query = op_q;
  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.pos_over = (32'(pos_q) > LEAVES);
  assign stat_o.clr_last = (32'(pos_q) == LEAVES);

  assign range_sum_o     = sum_out_q;
  assign status_o        = status_out_q;
  assign total_is_zero_o = tz_q;

endmodule

// File: rtl/lrast_ctrl.sv
// Controller: sequences the clearing sweep, update walks and prefix walks.
module lrast_ctrl
  import lrast_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_FIRST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      done_q  <= cmd_o.finish;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.pos_op = PS_HOLD;
    cmd_o.res_op = RS_HOLD;
    cmd_o.mul_a  = MA_AMT;
    cmd_o.mul_b  = MB_LM1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.pos_op = PS_INC;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        phase_d = PH_FIRST;
        if (stat_i.err) begin
          state_d = S_DONE;
        end else if (stat_i.op_query) begin
          cmd_o.res_op  = RS_CLEAR;
          cmd_o.acc_clr = 1'b1;
          cmd_o.pos_op  = PS_R;
          state_d       = S_Q_RD;
        end else begin
          cmd_o.pos_op = PS_L;
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_b  = MB_LM1;
          state_d      = S_A_SET;
        end
      end
      S_A_SET: begin
        cmd_o.set_dlt = 1'b1;
        cmd_o.neg     = (phase_q == PH_SECOND);
        state_d       = S_A_RD;
      end
      S_A_RD: begin
        if (stat_i.pos_over) begin
          cmd_o.mul_en = 1'b1;
          if (phase_q == PH_FIRST) begin
            cmd_o.pos_op = PS_R1;
            cmd_o.mul_b  = MB_R;
            phase_d      = PH_SECOND;
            state_d      = S_A_SET;
          end else begin
            cmd_o.mul_b = MB_LEN;
            state_d     = S_A_TOT;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_A_WR;
        end
      end
      S_A_WR: begin
        cmd_o.upd_wr = 1'b1;
        cmd_o.pos_op = PS_UP;
        state_d      = S_A_RD;
      end
      S_A_TOT: begin
        cmd_o.tot_add = 1'b1;
        state_d       = S_DONE;
      end
      S_Q_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_a  = MA_ACC_LO;
          cmd_o.mul_b  = (phase_q == PH_FIRST) ? MB_R : MB_LM1;
          state_d      = S_Q_MH;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.pos_op  = PS_DOWN;
        state_d       = S_Q_RD;
      end
      S_Q_MH: begin
        cmd_o.res_op = RS_PROD;
        cmd_o.neg    = (phase_q == PH_SECOND);
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = MA_ACC_HI;
        cmd_o.mul_b  = (phase_q == PH_FIRST) ? MB_R : MB_LM1;
        state_d      = S_Q_C1;
      end
      S_Q_C1: begin
        cmd_o.res_op = RS_PROD;
        cmd_o.neg    = (phase_q == PH_SECOND);
        state_d      = S_Q_C2;
      end
      S_Q_C2: begin
        cmd_o.res_op = RS_ACC2;
        cmd_o.neg    = (phase_q == PH_FIRST);
        if (phase_q == PH_FIRST) begin
          cmd_o.pos_op  = PS_LM1;
          cmd_o.acc_clr = 1'b1;
          phase_d       = PH_SECOND;
          state_d       = S_Q_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: rtl/lazy_range_add_range_sum_tree_core.sv
// Range-add / range-sum core: LEAVES signed elements, one result per request.
//
// Element values are held as two binary-indexed stores (LEAVES+1 words each);
// any range sum they give equals that of a lazy segment tree over the same
// elements, wrapped modulo 2^SUM_BITS. After reset the core sweeps both
// stores to zero, one word a cycle, LEAVES+1 words with busy high. A
// request is taken when start is high and busy low; it then costs up to
// about 2*log2(LEAVES) store steps (read, then write or accumulate). The
// result appears for one cycle with done_o and cannot be held off; busy is
// low in that same cycle, so the next request may follow at once. status_o
// flags out-of-range indices before reversed ranges; range_sum_o is zero
// for adds and rejects, and total_is_zero_o follows every request.
module lazy_range_add_range_sum_tree_core
  import lrast_pkg::*;
#(
  parameter int unsigned LEAVES   = LEAVES_DEF,
  parameter int unsigned SUM_BITS = SUM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        last_index_i,
  input  logic signed [AMT_W-1:0] amount_i,
  output logic                    done_o,
  output logic signed [RES_W-1:0] range_sum_o,
  output logic [1:0]              status_o,
  output logic                    total_is_zero_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence each request through the stores
  lrast_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // hold the stores, walk position and running sums
  lrast_dpath #(
    .LEAVES   (LEAVES),
    .SUM_BITS (SUM_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .amount_i        (amount_i),
    .range_sum_o     (range_sum_o),
    .status_o        (status_o),
    .total_is_zero_o (total_is_zero_o)
  );

  // an accepted request keeps the core busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but core not busy");

  // a result never lasts more than one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // rejected requests report a zero sum
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STATUS_OK |-> range_sum_o == '0)
    else $error("rejected request with non-zero sum");

  // no result while a request is still being worked on
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

endmodule

// File: tb/tb_lazy_range_add_range_sum_tree_core.sv
// Self-checking testbench for the range-add / range-sum tree core.
module tb_lazy_range_add_range_sum_tree_core;
  import lrast_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NLEAF = LEAVES_DEF;
  localparam int unsigned LIMIT = 2_000_000;

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  last;
    logic [AMT_W-1:0]  amt;
    logic              known;   // expected result typed in below
    logic [RES_W-1:0]  sum;
    status_e           status;
    logic              zero;
  } request_t;

  typedef struct {
    logic [RES_W-1:0] sum;
    status_e          status;
    logic             zero;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = 1'b0;
  logic [IDX_W-1:0] first_index_i = '0;
  logic [IDX_W-1:0] last_index_i = '0;
  logic signed [AMT_W-1:0] amount_i = '0;
  logic done_o;
  logic signed [RES_W-1:0] range_sum_o;
  logic [1:0] status_o;
  logic total_is_zero_o;

  // Flat copy of the element array: the tree only changes how sums are formed.
  logic [63:0] elem_values [1:NLEAF];
  answer_t     pending_answers [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned taken = 0;   // requests accepted so far

  lazy_range_add_range_sum_tree_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Bound the run; a hang shows up as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (start && !busy && rst_ni) taken <= taken + 1;
  end

  // Apply a request to the element copy and return what the core should report.
  function automatic answer_t predict_range_op(request_t rq);
    answer_t a;
    logic [63:0] amt64, total;
    a.sum = '0;
    a.status = STATUS_OK;
    amt64 = {{32{rq.amt[31]}}, rq.amt};
    if (rq.first == 0 || rq.last == 0 || rq.first > NLEAF || rq.last > NLEAF)
      a.status = STATUS_RANGE;
    else if (rq.last < rq.first)
      a.status = STATUS_REVERSED;
    else begin
      for (int i = rq.first; i <= rq.last; i++) begin
        if (rq.op) a.sum += elem_values[i];
        else elem_values[i] += amt64;
      end
    end
    total = '0;
    for (int i = 1; i <= NLEAF; i++) total += elem_values[i];
    a.zero = (total == 0);
    return a;
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: range_sum %0h", range_sum_o);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (range_sum_o !== e.sum) begin
          $error("range_sum expected %0h actual %0h", e.sum, range_sum_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (total_is_zero_o !== e.zero) begin
          $error("total_is_zero expected %0b actual %0b", e.zero, total_is_zero_o);
          errors++;
        end
      end
    end
  end

  // Hold start until the core takes the request, queueing the prediction.
  task automatic issue_request(request_t rq, bit gaps);
    answer_t a;
    int unsigned taken_prev;
    a = predict_range_op(rq);
    if (rq.known && (a.sum !== rq.sum || a.status !== rq.status || a.zero !== rq.zero)) begin
      $error("table row disagrees with predictor: first %0d last %0d", rq.first, rq.last);
      errors++;
    end
    pending_answers.push_back(a);
    taken_prev = taken;
    start <= 1'b1;
    operation_i <= rq.op;
    first_index_i <= rq.first;
    last_index_i <= rq.last;
    amount_i <= rq.amt;
    do @(posedge clk_i); while (taken == taken_prev);
    // Drop start only when a gap follows; back-to-back requests keep it high.
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      operation_i <= 1'($urandom_range(0, 1));
      first_index_i <= IDX_W'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic request_t row(logic op, int f, int l, logic [31:0] amt,
                                   logic known = 0, logic [63:0] sum = 0,
                                   status_e st = STATUS_OK, logic zero = 1);
    request_t r;
    r.op = op; r.first = IDX_W'(f); r.last = IDX_W'(l); r.amt = amt;
    r.known = known; r.sum = sum; r.status = st; r.zero = zero;
    return r;
  endfunction

  // Mostly small ranges, sometimes the whole array or out-of-range indices.
  function automatic request_t random_request();
    request_t r;
    int f, w;
    r.known = 0; r.sum = '0; r.status = STATUS_OK; r.zero = 0;
    r.op = 1'($urandom_range(0, 1));
    r.amt = $urandom;
    case ($urandom_range(0, 9))
      0: r.amt = $urandom_range(0, 3) - 1;
      1: r.amt = {1'($urandom_range(0, 1)), 31'h0} - $urandom_range(0, 1);
      default: ;
    endcase
    case ($urandom_range(0, 19))
      0: begin r.first = IDX_W'($urandom); r.last = IDX_W'($urandom); end
      1: begin
        r.first = IDX_W'(NLEAF - $urandom_range(0, 40));
        r.last = IDX_W'($urandom_range(1, 40));
      end
      2: begin r.first = IDX_W'(1); r.last = IDX_W'(NLEAF); end
      default: begin
        f = $urandom_range(1, NLEAF);
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NLEAF) : $urandom_range(0, 8);
        r.first = IDX_W'(f);
        r.last = (f + w > NLEAF) ? IDX_W'(NLEAF) : IDX_W'(f + w);
      end
    endcase
    return r;
  endfunction

  initial begin
    request_t table_rows [$];
    for (int i = 1; i <= NLEAF; i++) elem_values[i] = '0;

    // Directed rows: rejects, extremes, point and whole-array operations.
    table_rows = '{
      row(1, 1, NLEAF, 0, 1, 0, STATUS_OK, 1),
      row(1, 0, 5, 0, 1, 0, STATUS_RANGE, 1),
      row(0, 5, 0, 7, 1, 0, STATUS_RANGE, 1),
      row(0, NLEAF + 1, 2047, 7, 1, 0, STATUS_RANGE, 1),
      row(1, 2047, 3, 0, 1, 0, STATUS_RANGE, 1),
      row(0, 9, 3, 7, 1, 0, STATUS_REVERSED, 1),
      row(0, 1, 1, 32'h7FFF_FFFF),
      row(1, 1, 1, 0),
      row(0, NLEAF, NLEAF, 32'h8000_0000),
      row(1, NLEAF, NLEAF, 32'h5555_5555),
      row(1, 1, NLEAF, 0),
      row(0, 1, NLEAF, 32'hFFFF_FFFF),
      row(0, 2, NLEAF - 1, 32'h8000_0000),
      row(1, 1, NLEAF, 0),
      row(0, 3, 3, 32'h1234_5678),
      row(1, 2, 4, 0),
      row(0, NLEAF, 1, 1, 1, 0, STATUS_REVERSED, 0),
      row(1, 512, 513, 0),
      row(0, 300, 700, 32'hAAAA_AAAA),
      row(1, 299, 701, 0),
      row(1, 1, NLEAF, 0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) issue_request(table_rows[i], 1'b1);

    // Let the queue drain once before the random part.
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);

    for (int n = 0; n < 1130; n++) issue_request(random_request(), n < 1000);

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
